// ----- hw/rtl/lsrk_pkg.sv -----
// Shared types and command codes for the LIFO stack with removal by key.
package lsrk_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_e;

    // Command information broadcast to every cell in the same cycle.
    typedef struct packed {
        logic              push_en;
        logic              remove_en;
        logic [BYTE_W-1:0] data;
    } cell_cmd_t;

    // Where a cell stands relative to the current fill count.
    typedef struct packed {
        logic below;   // cell holds a live entry
        logic at;      // cell is the first free slot
        logic top;     // cell holds the top entry
    } cell_pos_t;

    // Signals rippling from the top cell toward the bottom cell.
    typedef struct packed {
        logic              found;   // a matching entry exists at or above this cell
        logic [BYTE_W-1:0] top;     // value of the top entry, zero if none seen yet
    } cell_chain_t;

endpackage

// ----- hw/rtl/lsrk_cell.sv -----
// One stack cell: holds one entry, compares it with the key and shifts down on removal.
module lsrk_cell
    import lsrk_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  cell_pos_t         pos,
    input  logic              key_hit,
    input  logic [BYTE_W-1:0] upper_entry,
    input  cell_chain_t       chain_in,
    output cell_chain_t       chain_out,
    output logic [BYTE_W-1:0] entry
);

    logic [BYTE_W-1:0] entry_reg;
    logic [BYTE_W-1:0] entry_next;
    logic              match;

    always_comb
    begin
        match           = cmd.remove_en && pos.below && (entry_reg == cmd.data);
        chain_out.found = chain_in.found || match;
        chain_out.top   = pos.top ? entry_reg : chain_in.top;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push_en && pos.at)
        begin
            entry_next = cmd.data;
        end
        else if (cmd.remove_en && key_hit && !chain_in.found)
        begin
            // No match lies above this cell, so it sits at or above the topmost match.
            // The removed entry and everything above it take the value from one place up.
            entry_next = upper_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/lifo_stack_remove_key.sv -----
// Top level of the LIFO stack with push, pop and removal by key, built as a row of cells.
//
//  channel   direction  tdata (low bit up)                    tuser
//  s_*       in         data_byte[7:0]                        command[1:0]
//  m_*       out        ok, popped_byte[7:0], entry_count     -
//
//  One command is taken per cycle; its result appears in the output register the
//  cycle after acceptance. The key search ripples from the top cell to the bottom
//  cell within that cycle, so removal costs no more cycles than push or pop.
//  Reset empties the stack at once; entries need no clearing.
//  While a result waits on m_tready, a new command is taken only as the result leaves.
module lifo_stack_remove_key
    import lsrk_pkg::*;
#(
    parameter int unsigned DEPTH = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // data_byte[7:0]
    input  logic [1:0]                          s_tuser,   // command[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ok[0], popped_byte[8:1], entry_count above, zero fill to a byte boundary
    output logic [((1+BYTE_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned RES_W   = 1 + BYTE_W + CNT_W;
    localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [BYTE_W-1:0] popped_reg;
    logic [BYTE_W-1:0] popped_next;

    logic              accept;
    logic              full;
    logic              empty;
    cell_cmd_t         cmd;
    cell_pos_t         pos      [DEPTH];
    cell_chain_t       chain    [DEPTH+1];
    logic [BYTE_W-1:0] entries  [DEPTH+1];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        cmd.push_en   = accept && (s_tuser == CMD_PUSH) && !full;
        cmd.remove_en = accept && (s_tuser == CMD_REMOVE);
        cmd.data      = s_tdata;
    end

    // Nothing lies above the top cell.
    assign chain[DEPTH].found = 1'b0;
    assign chain[DEPTH].top   = '0;
    assign entries[DEPTH]     = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            always_comb
            begin
                pos[gi].below = (CNT_W'(gi) < count_reg);
                pos[gi].at    = (CNT_W'(gi) == count_reg);
                pos[gi].top   = (CNT_W'(gi + 1) == count_reg);
            end

            lsrk_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .pos         (pos[gi]),
                .key_hit     (chain[0].found),
                .upper_entry (entries[gi+1]),
                .chain_in    (chain[gi+1]),
                .chain_out   (chain[gi]),
                .entry       (entries[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        ok_next     = 1'b0;
        popped_next = '0;
        case (s_tuser)
            CMD_PUSH:
            begin
                ok_next = !full;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP:
            begin
                ok_next = !empty;
                if (!empty)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    popped_next = chain[0].top;
                end
            end
            CMD_REMOVE:
            begin
                // A match can only be found among live entries, so this also covers empty.
                ok_next = chain[0].found;
                if (chain[0].found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg     <= ok_next;
            popped_reg <= popped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, count_reg, popped_reg, ok_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == CMD_PUSH) && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("fill count changed without a command");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !ok_reg) |-> (popped_reg == '0))
        else $error("failed command reports a popped byte");

endmodule
